// ===== rtl/core/ksel_pkg.sv =====
// Package for the k-smallest index selector: beat types and shared constants.
`timescale 1ns / 1ps
package ksel_pkg;

  localparam int unsigned DistW  = 32;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned RankOW = 3;

  // One input beat: a row element.
  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             row_end;
  } ksel_in_t;

  // One output beat: a ranked neighbor.
  typedef struct packed {
    logic [IdxW-1:0]   neighbor_index;
    logic [DistW-1:0]  neighbor_distance;
    logic [RankOW-1:0] rank;
    logic              slot_valid;
    logic              last_of_run;
  } ksel_out_t;

  // One kept entry of the sorted list.
  typedef struct packed {
    logic [DistW-1:0] distance;
    logic [IdxW-1:0]  idx;
    logic             valid;
  } ksel_entry_t;

  // Value of an empty slot.
  localparam ksel_entry_t EntryCleared = '{distance: '1, idx: '0, valid: 1'b0};

endpackage

// ===== rtl/core/k_smallest_index_selector_unit.sv =====
// Top level of the k-smallest index selector: insertion chain, result chain, handshakes.
`timescale 1ns / 1ps
// Streams one row of distances, one element per beat, and keeps the K smallest with their
// row positions in a chain of K compare-and-shift cells, so a new element is taken every
// cycle but for a waiting row_end beat. Equal distances keep the earlier position first.
// On the row_end beat the sorted chain is copied into a K-deep output shift chain and the
// insertion chain clears, so the next row starts in the very next cycle while the K
// results drain one per cycle whenever out_ready_i is high, nearest first. Input beats
// without row_end are never stalled; a row_end beat waits until all K results of the
// previous row have been taken. Elements past MAX_ROW positions are dropped; rows shorter
// than K give slot_valid low.
module k_smallest_index_selector_unit #(
  parameter int unsigned K       = 8,
  parameter int unsigned MAX_ROW = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ksel_pkg::ksel_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ksel_pkg::ksel_out_t out_data_o
);
  import ksel_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_ROW + 1);
  localparam int unsigned CntW = $clog2(K + 1);

  logic            in_fire, out_fire, load, ins;
  logic [PosW-1:0] pos_q, pos_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] rank_full;

  logic        take      [K];
  ksel_entry_t ent       [K];
  ksel_entry_t ent_ins   [K];
  ksel_entry_t out_ent   [K];

  // Handshakes
  assign in_ready_o  = !in_data_i.row_end || (cnt_q == '0);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign load        = in_fire && in_data_i.row_end;
  assign ins         = in_fire && (pos_q < PosW'(MAX_ROW));

  // Row position, saturating at MAX_ROW, cleared at row end
  always_comb begin
    pos_d = pos_q;
    if (load) begin
      pos_d = '0;
    end else if (ins) begin
      pos_d = pos_q + PosW'(1);
    end
  end

  // Results left to drain
  always_comb begin
    cnt_d = cnt_q;
    if (load) begin
      cnt_d = CntW'(K);
    end else if (out_fire) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cnt_q <= '0;
    end else begin
      pos_q <= pos_d;
      cnt_q <= cnt_d;
    end
  end

  // Insertion chain and result chain
  for (genvar i = 0; i < K; i++) begin : g_chain
    logic        left_take;
    ksel_entry_t left_entry;
    ksel_entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_take  = 1'b0;
      assign left_entry = EntryCleared;
    end else begin : g_body
      assign left_take  = take[i-1];
      assign left_entry = ent[i-1];
    end

    if (i == K - 1) begin : g_tail
      assign right_entry = EntryCleared;
    end else begin : g_mid
      assign right_entry = out_ent[i+1];
    end

    ksel_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ins_i        (ins),
      .clear_i      (load),
      .new_dist_i   (in_data_i.distance),
      .new_idx_i    (IdxW'(pos_q)),
      .left_take_i  (left_take),
      .left_entry_i (left_entry),
      .take_o       (take[i]),
      .entry_o      (ent[i]),
      .entry_ins_o  (ent_ins[i])
    );

    ksel_out_cell u_out_cell (
      .clk_i         (clk_i),
      .load_i        (load),
      .load_entry_i  (ent_ins[i]),
      .shift_i       (out_fire),
      .right_entry_i (right_entry),
      .entry_o       (out_ent[i])
    );
  end

  // Output beat from the head of the result chain
  assign rank_full = CntW'(K) - cnt_q;

  always_comb begin
    out_data_o.neighbor_index    = out_ent[0].idx;
    out_data_o.neighbor_distance = out_ent[0].distance;
    out_data_o.rank              = RankOW'(rank_full);
    out_data_o.slot_valid        = out_ent[0].valid;
    out_data_o.last_of_run       = (cnt_q == CntW'(1));
  end

endmodule

// ===== rtl/core/ksel_cell.sv =====
// One cell of the insertion chain: holds one sorted entry, takes the new element or its neighbor.
`timescale 1ns / 1ps
module ksel_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         ins_i,
  input  logic                         clear_i,
  input  logic [ksel_pkg::DistW-1:0]   new_dist_i,
  input  logic [ksel_pkg::IdxW-1:0]    new_idx_i,
  input  logic                         left_take_i,
  input  ksel_pkg::ksel_entry_t        left_entry_i,
  output logic                         take_o,
  output ksel_pkg::ksel_entry_t        entry_o,
  output ksel_pkg::ksel_entry_t        entry_ins_o
);
  import ksel_pkg::*;

  ksel_entry_t entry_q, entry_d;

  // Strict compare keeps the earlier index ahead on ties.
  assign take_o = ins_i && (!entry_q.valid || (new_dist_i < entry_q.distance));

  // Contents after this element goes in.
  always_comb begin
    if (left_take_i) begin
      entry_ins_o = left_entry_i;
    end else if (take_o) begin
      entry_ins_o = '{distance: new_dist_i, idx: new_idx_i, valid: 1'b1};
    end else begin
      entry_ins_o = entry_q;
    end
  end

  assign entry_d = clear_i ? EntryCleared : entry_ins_o;
  assign entry_o = entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= EntryCleared;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule

// ===== rtl/core/ksel_out_cell.sv =====
// One cell of the result chain: loaded in parallel at row end, shifts toward the head per beat.
`timescale 1ns / 1ps
module ksel_out_cell (
  input  logic                  clk_i,
  input  logic                  load_i,
  input  ksel_pkg::ksel_entry_t load_entry_i,
  input  logic                  shift_i,
  input  ksel_pkg::ksel_entry_t right_entry_i,
  output ksel_pkg::ksel_entry_t entry_o
);
  import ksel_pkg::*;

  ksel_entry_t entry_q, entry_d;

  // Load wins; the chain is empty whenever a load happens.
  always_comb begin
    if (load_i) begin
      entry_d = load_entry_i;
    end else if (shift_i) begin
      entry_d = right_entry_i;
    end else begin
      entry_d = entry_q;
    end
  end

  assign entry_o = entry_q;

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== rtl/core/ksel_checker.sv =====
// Port-level checker for the k-smallest index selector, bound to the top level.
`timescale 1ns / 1ps
module ksel_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input ksel_pkg::ksel_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ksel_pkg::ksel_out_t out_data_o
);
  import ksel_pkg::*;

  // Stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // A row end always produces a result beat in the next cycle.
  a_row_end_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.row_end |=> out_valid_o)
    else $error("no result after row end");

  // After the last beat of a run the output is not valid in the next cycle.
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last_of_run |=> !out_valid_o)
    else $error("result beat right after last of run");

  // Ranks within a run count up by one.
  a_rank_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_of_run |=>
      out_valid_o && (out_data_o.rank == RankOW'($past(out_data_o.rank) + 3'd1)))
    else $error("rank did not advance by one");

endmodule

bind k_smallest_index_selector_unit ksel_checker u_ksel_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
